/* src/bsq_pkg.sv */
// bsq_pkg: shared constants and types for the bounded smallest-k queue
// used by bsq_cell and bounded_smallest_k_queue; no dependencies
package bsq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // capacity register
   localparam int             CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes on req_kind
   typedef enum logic {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   // per-transaction control broadcast to every cell
   typedef struct packed {
      logic push;         // push that changes the list
      logic insert_open;  // count below capacity, list grows by one
      logic pop;          // pop on a non-empty list
   } cell_ctl_type;

endpackage

/* src/bsq_cell.sv */
// bsq_cell: one slot of the sorted list, compares against the broadcast key
// and shifts with its neighbors; depends on bsq_pkg
module bsq_cell
   import bsq_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int CNT_W       = 5,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  cell_ctl_type                  ctl,
   input  logic        [CNT_W-1:0]       count,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] prev_entry,
   input  logic                          prev_gt,
   input  logic signed [VALUE_WIDTH-1:0] next_entry,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output logic                          gt
);

   logic signed [VALUE_WIDTH-1:0] entry_ff;
   logic signed [VALUE_WIDTH-1:0] entry_in;
   logic                          occupied;
   logic                          tail;

   assign occupied = CNT_W'(INDEX) < count;
   assign tail     = (count == CNT_W'(INDEX)) && ctl.insert_open;
   assign gt       = occupied && (entry_ff > key);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = next_entry;
      end else if (ctl.push) begin
         // larger entries move up one slot, the first of them is replaced by the key
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt || tail) begin
            entry_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* src/bounded_smallest_k_queue.sv */
// bounded_smallest_k_queue: keeps the smallest signed values seen, sorted, in a row of cells
// depends on bsq_pkg and bsq_cell
//
//   channel  ports                                   direction  handshake
//   req      req_kind, req_value                     in         req_valid / req_ready
//   rsp      rsp_smallest, rsp_has_entry,            out        rsp_valid / rsp_ready
//            rsp_entry_count, rsp_push_kept
//   csr      csr_write_data (capacity)               in         csr_write_enable
//
// all cells compare and shift together in the accept cycle
// and the result is available on rsp the cycle after.
// req_ready is high while the result slot is empty or being drained, so a stalled rsp
// stalls req; one transaction per cycle when rsp_ready stays high.
// synchronous reset empties the list and sets capacity to 16; no clearing pass.
module bounded_smallest_k_queue
   import bsq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_WIDTH-1:0] rsp_smallest,
   output logic                          rsp_has_entry,
   output logic        [CNT_W-1:0]       rsp_entry_count,
   output logic                          rsp_push_kept,
   input  logic                          csr_write_enable,
   input  logic        [CAP_W-1:0]       csr_write_data
);

   localparam int W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             push_kept_ff, push_kept_in;

   logic                          req_fire;
   logic                          is_push;
   logic                          is_pop;
   logic [W-1:0]                  cap_ext;
   logic [W-1:0]                  eff_cap;
   logic                          insert_open;
   logic                          any_gt;
   cell_ctl_type                  ctl;
   logic [DEPTH-1:0]              gt_vec;
   logic signed [VALUE_WIDTH-1:0] entry [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_push   = (kind_type'(req_kind) == KIND_PUSH);
   assign is_pop    = (kind_type'(req_kind) == KIND_POP);

   // capacity zero acts as one, above the built depth acts as the depth
   assign cap_ext = W'(cap_ff);
   always_comb begin
      eff_cap = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = W'(1);
      end else if (cap_ext > W'(DEPTH)) begin
         eff_cap = W'(DEPTH);
      end
   end

   assign insert_open = W'(count_ff) < eff_cap;
   // larger entries form a suffix, so any of them means the last one is larger
   assign any_gt      = |gt_vec;

   assign ctl.insert_open = insert_open;
   assign ctl.push        = req_fire && is_push && (insert_open || any_gt);
   assign ctl.pop         = req_fire && is_pop && (count_ff != '0);

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] prev_entry;
         logic signed [VALUE_WIDTH-1:0] next_entry;
         logic                          prev_gt;

         if (i == 0) begin : g_first
            assign prev_entry = '0;
            assign prev_gt    = 1'b0;
         end else begin : g_mid
            assign prev_entry = entry[i-1];
            assign prev_gt    = gt_vec[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign next_entry = '0;
         end else begin : g_inner
            assign next_entry = entry[i+1];
         end

         bsq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (i)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .count      (count_ff),
            .key        (req_value),
            .prev_entry (prev_entry),
            .prev_gt    (prev_gt),
            .next_entry (next_entry),
            .entry      (entry[i]),
            .gt         (gt_vec[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      push_kept_in = push_kept_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         push_kept_in = ctl.push;
         if (ctl.pop) begin
            count_in = count_ff - CNT_W'(1);
         end else if (ctl.push && insert_open) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         push_kept_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         push_kept_ff <= push_kept_in;
      end
   end

   // list state only moves on an accepted transaction, so it backs the result directly
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_entry   = (count_ff != '0);
   assign rsp_smallest    = (count_ff != '0) ? entry[0] : '0;
   assign rsp_entry_count = count_ff;
   assign rsp_push_kept   = push_kept_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      W'(count_ff) <= W'(DEPTH))
      else $error("entry count above depth");

   a_full_push_holds_count : assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_push && !insert_open) |=> $stable(count_ff))
      else $error("push on a full list changed the count");

   a_pop_empty_no_change : assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && (count_ff == '0)) |=> (count_ff == '0) && !push_kept_ff)
      else $error("pop on an empty list changed state");

   a_kept_needs_push : assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop) |=> !push_kept_ff)
      else $error("pop reported a kept push");

   generate
      if (DEPTH > 1) begin : g_order_check
         a_head_sorted : assert property (@(posedge clock) disable iff (reset)
            (W'(count_ff) >= W'(2)) |-> (entry[0] <= entry[1]))
            else $error("first two entries out of order");
      end
   endgenerate

endmodule

/* test/bounded_smallest_k_queue_test.sv */
// bounded_smallest_k_queue_test: self-checking bench for the bounded smallest-k queue
// predicts every report from its own sorted list and checks the rsp channel against it
// depends on bsq_pkg and bounded_smallest_k_queue
module bounded_smallest_k_queue_test
   import bsq_pkg::*;
;
   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int VW             = VALUE_WIDTH_DEFAULT;
   localparam int COUNT_W        = $clog2(DEPTH + 1);
   localparam int PHASES         = 12;
   localparam int PHASE_ITEMS    = 160;
   localparam int RX_STALL_LEN   = 80;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

   typedef struct {
      logic signed [VW-1:0] smallest;
      logic                 has_entry;
      logic [COUNT_W-1:0]   entry_count;
      logic                 push_kept;
   } queue_report_type;

   // sorted copy of the stored values plus the reports still owed by the block
   class smallest_k_tracker;
      logic signed [VW-1:0] held[$];
      logic [CAP_W-1:0]     capacity;
      queue_report_type     expected_reports[$];
      int errors, kept_pushes, dropped_pushes, evictions, empty_pops, deepest;

      function new();
         capacity = CAP_RESET;
      endfunction

      function void write_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int outstanding();
         return expected_reports.size();
      endfunction

      function void note_queue_op(kind_type kind, logic signed [VW-1:0] value);
         int limit;
         int pos;
         queue_report_type rep;
         limit = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
         rep.push_kept = 1'b0;
         if (kind == KIND_PUSH) begin
            if (held.size() < limit || held[$] > value) begin
               // full (or over a lowered capacity): the largest entry makes room
               if (held.size() >= limit) begin
                  void'(held.pop_back());
                  evictions++;
               end
               pos = 0;
               while (pos < held.size() && held[pos] <= value) pos++;
               held.insert(pos, value);
               rep.push_kept = 1'b1;
               kept_pushes++;
            end else begin
               dropped_pushes++;
            end
         end else if (held.size() > 0) begin
            void'(held.pop_front());
         end else begin
            empty_pops++;
         end
         if (held.size() > deepest) deepest = held.size();
         rep.smallest    = (held.size() > 0) ? held[0] : '0;
         rep.has_entry   = (held.size() > 0);
         rep.entry_count = COUNT_W'(held.size());
         expected_reports.push_back(rep);
      endfunction

      function void log_mismatch(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
      endfunction

      function void check_queue_report(logic signed [VW-1:0] smallest, logic has_entry,
                                       logic [COUNT_W-1:0] entry_count, logic push_kept);
         queue_report_type exp;
         if (expected_reports.size() == 0) begin
            log_mismatch($sformatf("unexpected report: smallest %0d has %b count %0d kept %b",
                                   smallest, has_entry, entry_count, push_kept));
            return;
         end
         exp = expected_reports.pop_front();
         if (exp.smallest !== smallest || exp.has_entry !== has_entry ||
             exp.entry_count !== entry_count || exp.push_kept !== push_kept)
            log_mismatch($sformatf({"report mismatch: expected smallest %0d has %b count %0d ",
                                    "kept %b, got smallest %0d has %b count %0d kept %b"},
                                   exp.smallest, exp.has_entry, exp.entry_count,
                                   exp.push_kept, smallest, has_entry, entry_count,
                                   push_kept));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_kind;
   logic signed [VW-1:0] req_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [VW-1:0] rsp_smallest;
   logic                 rsp_has_entry;
   logic [COUNT_W-1:0]   rsp_entry_count;
   logic                 rsp_push_kept;
   logic                 csr_write_enable;
   logic [CAP_W-1:0]     csr_write_data;

   smallest_k_tracker tracker = new();

   bit tx_gaps_on    = 1'b1;
   bit rx_gaps_on    = 1'b1;
   bit rx_long_stall = 1'b0;
   int items_sent    = 0;
   int cap_writes    = 0;
   int idle_cycles   = 0;

   int phase_caps[PHASES]     = '{1, 16, 31, 0, 17, 2, 8, 16, 5, 15, 3, 16};
   int phase_push_pct[PHASES] = '{60, 75, 80, 55, 70, 50, 65, 40, 60, 75, 55, 60};

   bounded_smallest_k_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_smallest     (rsp_smallest),
      .rsp_has_entry    (rsp_has_entry),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_push_kept    (rsp_push_kept),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // results are checked before the transaction accepted at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_queue_report(rsp_smallest, rsp_has_entry, rsp_entry_count,
                                       rsp_push_kept);
         if (req_valid && req_ready) tracker.note_queue_op(kind_type'(req_kind), req_value);
         if (csr_write_enable) tracker.write_capacity(csr_write_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_long_stall) begin
            rx_long_stall = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RX_STALL_LEN) @(posedge clock);
         end
         rsp_ready <= !rx_gaps_on || ($urandom_range(99) >= 22);
      end
   end

   // returns at the edge where the transaction is accepted, with req_valid still high
   task automatic send_item(kind_type kind, logic signed [VW-1:0] value);
      while (tx_gaps_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         req_kind  <= 1'($urandom_range(1));
         req_value <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      items_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      cap_writes++;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int cap, int push_pct, bit with_long_stall);
      logic signed [VW-1:0] value;
      int pick;
      kind_type kind;
      set_capacity(CAP_W'(cap));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (with_long_stall && i == PHASE_ITEMS / 3) rx_long_stall = 1'b1;
         pick = $urandom_range(99);
         // narrow values give plenty of ties and compares against the largest entry
         if (pick < 45) begin
            value = $urandom_range(20) - 10;
         end else if (pick < 85) begin
            value = $urandom;
         end else begin
            case ($urandom_range(3))
               0: value = VAL_MIN;
               1: value = VAL_MAX;
               2: value = '0;
               default: value = '1;
            endcase
         end
         kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
         send_item(kind, value);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_PUSH;
      req_value        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, ties, then small capacities below the count
      send_item(KIND_POP, 32'sd77);
      send_item(KIND_PUSH, VAL_MAX);
      send_item(KIND_PUSH, VAL_MIN);
      send_item(KIND_PUSH, 0);
      send_item(KIND_PUSH, -1);
      send_item(KIND_PUSH, 1);
      send_item(KIND_PUSH, 5);
      send_item(KIND_PUSH, 5);
      send_item(KIND_POP, 0);
      send_item(KIND_POP, -1);
      set_capacity(CAP_W'(3));
      send_item(KIND_PUSH, 7);
      send_item(KIND_PUSH, 7);
      send_item(KIND_PUSH, -5);
      send_item(KIND_POP, 0);
      send_item(KIND_POP, 0);
      send_item(KIND_POP, 0);
      send_item(KIND_PUSH, 100);
      send_item(KIND_PUSH, 200);
      set_capacity(CAP_W'(0));
      send_item(KIND_PUSH, 50);
      repeat (4) send_item(KIND_POP, VAL_MAX);
      send_item(KIND_PUSH, VAL_MIN);
      send_item(KIND_PUSH, VAL_MIN);

      for (int p = 0; p < PHASES; p++) begin
         // one phase with no idling on either side
         tx_gaps_on = (p != 2);
         rx_gaps_on = (p != 2);
         run_phase(phase_caps[p], phase_push_pct[p], p == 4);
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         tracker.errors += tracker.outstanding();
         $display("%0d reports never arrived", tracker.outstanding());
      end
      $display("ran %0d queue ops over %0d capacity writes, list depth up to %0d",
               items_sent, cap_writes, tracker.deepest);
      $display("pushes kept %0d, dropped %0d, evictions %0d, pops on empty %0d, errors %0d",
               tracker.kept_pushes, tracker.dropped_pushes, tracker.evictions,
               tracker.empty_pops, tracker.errors);
      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
src/bsq_pkg.sv
src/bsq_cell.sv
src/bounded_smallest_k_queue.sv
test/bounded_smallest_k_queue_test.sv
